// ----- src/sasc_pkg.sv -----
// Shared types and constants for the two-register stack machine block.
// Used by sasc_core and simple_accumulator_stack_cpu_top; no dependencies.
package sasc_pkg;

  // Item kinds on the input channel
  localparam logic [1:0] FN_LOAD    = 2'd0;
  localparam logic [1:0] FN_STEP    = 2'd1;
  localparam logic [1:0] FN_READ    = 2'd2;
  localparam logic [1:0] FN_RESTART = 2'd3;

  // Instruction opcodes
  localparam logic [7:0] OP_LDC    = 8'd0;
  localparam logic [7:0] OP_ADC    = 8'd1;
  localparam logic [7:0] OP_LDL    = 8'd2;
  localparam logic [7:0] OP_STL    = 8'd3;
  localparam logic [7:0] OP_LDNL   = 8'd4;
  localparam logic [7:0] OP_STNL   = 8'd5;
  localparam logic [7:0] OP_ADD    = 8'd6;
  localparam logic [7:0] OP_SUB    = 8'd7;
  localparam logic [7:0] OP_SHL    = 8'd8;
  localparam logic [7:0] OP_SHR    = 8'd9;
  localparam logic [7:0] OP_ADJ    = 8'd10;
  localparam logic [7:0] OP_A2SP   = 8'd11;
  localparam logic [7:0] OP_SP2A   = 8'd12;
  localparam logic [7:0] OP_CALL   = 8'd13;
  localparam logic [7:0] OP_RETURN = 8'd14;
  localparam logic [7:0] OP_BRZ    = 8'd15;
  localparam logic [7:0] OP_BRLZ   = 8'd16;
  localparam logic [7:0] OP_BR     = 8'd17;
  localparam logic [7:0] OP_HALT   = 8'd18;
  // Data directives: stored as sign-extended operand
  localparam logic [7:0] OP_DATA   = 8'd19;
  localparam logic [7:0] OP_SET    = 8'd20;

  // Result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_HALTED  = 3'd1;
  localparam logic [2:0] ST_LOOP    = 3'd2;
  localparam logic [2:0] ST_REJECT  = 3'd3;
  localparam logic [2:0] ST_STOPPED = 3'd4;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] object_word;
    logic [13:0] read_address;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        program_counter;
    logic signed [31:0] stack_pointer;
    logic signed [31:0] reg_a;
    logic signed [31:0] reg_b;
    logic signed [31:0] read_data;
    logic [2:0]         status;
    logic [31:0]        executed_count;
  } out_item_t;

  // Upper 24 bits of a word, sign-extended to 32
  function automatic logic [31:0] operand_of(input logic [31:0] w);
    operand_of = {{8{w[31]}}, w[31:8]};
  endfunction

endpackage

// ----- src/sasc_mem.sv -----
// Single-port word memory with registered read.
// No dependencies; instantiated by simple_accumulator_stack_cpu_top.
module sasc_mem #(
  parameter int MEM_DEPTH = 16384
) (
  input  logic                         clk,
  input  logic                         mem_en,
  input  logic                         mem_we,
  input  logic [$clog2(MEM_DEPTH)-1:0] mem_addr,
  input  logic [31:0]                  mem_wdata,
  output logic [31:0]                  mem_rdata
);

  logic [31:0] mem_r [MEM_DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_en) begin
      if (mem_we) begin
        mem_r[mem_addr] <= mem_wdata;
      end else begin
        rdata_r <= mem_r[mem_addr];
      end
    end
  end

  assign mem_rdata = rdata_r;

endmodule

// ----- src/sasc_core.sv -----
// Sequencer for the stack machine: decodes items, fetches and executes over memory.
// Depends on sasc_pkg; drives the port of sasc_mem.
module sasc_core
  import sasc_pkg::*;
#(
  parameter int MEM_DEPTH = 16384
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  in_item_t                     in_data,
  output logic                         res_valid,
  input  logic                         res_ready,
  output out_item_t                    res_data,
  output logic                         mem_en,
  output logic                         mem_we,
  output logic [$clog2(MEM_DEPTH)-1:0] mem_addr,
  output logic [31:0]                  mem_wdata,
  input  logic [31:0]                  mem_rdata
);

  localparam int AW = $clog2(MEM_DEPTH);
  localparam logic [31:0] SP_INIT = 32'(MEM_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_LDWAIT, S_RDWAIT, S_DONE
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] a_r, a_nxt;
  logic [31:0] b_r, b_nxt;
  logic [31:0] pc_r, pc_nxt;
  logic [31:0] sp_r, sp_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic        halted_r, halted_nxt;
  logic [AW-1:0] lp_r, lp_nxt;
  logic [31:0] rdata_r, rdata_nxt;
  logic [2:0]  status_r, status_nxt;

  // Execute-stage decode of the fetched word
  logic [7:0]  ex_op;
  logic [31:0] ex_opd;
  logic [31:0] ex_pc_tgt;
  logic [31:0] ex_ea;
  logic [31:0] ex_a, ex_b, ex_sp, ex_pc_base, ex_pc_next, ex_wdata;
  logic        ex_rd, ex_wr, ex_halt, ex_loop;
  logic [7:0]  ld_op;
  logic        in_acc;

  assign in_acc = in_valid && !in_stall;
  assign ld_op  = in_data.object_word[7:0];

  always_comb begin
    ex_op     = mem_rdata[7:0];
    ex_opd    = operand_of(mem_rdata);
    ex_pc_tgt = pc_r + ex_opd;
    ex_ea     = ((ex_op == OP_LDNL || ex_op == OP_STNL) ? a_r : sp_r) + ex_opd;
    ex_a       = a_r;
    ex_b       = b_r;
    ex_sp      = sp_r;
    ex_pc_base = pc_r;
    ex_wdata   = a_r;
    ex_rd      = 1'b0;
    ex_wr      = 1'b0;
    ex_halt    = 1'b0;
    unique case (ex_op)
      OP_LDC:  begin ex_b = a_r; ex_a = ex_opd; end
      OP_ADC:  ex_a = a_r + ex_opd;
      OP_LDL:  begin ex_b = a_r; ex_rd = 1'b1; end
      OP_STL:  begin ex_wr = 1'b1; ex_wdata = a_r; ex_a = b_r; end
      OP_LDNL: ex_rd = 1'b1;
      OP_STNL: begin ex_wr = 1'b1; ex_wdata = b_r; end
      OP_ADD:  ex_a = a_r + b_r;
      OP_SUB:  ex_a = b_r - a_r;
      OP_SHL:  ex_a = b_r << a_r[4:0];
      OP_SHR:  ex_a = 32'($signed(b_r) >>> a_r[4:0]);
      OP_ADJ:  ex_sp = sp_r + ex_opd;
      OP_A2SP: begin ex_sp = a_r; ex_a = b_r; end
      OP_SP2A: begin ex_b = a_r; ex_a = sp_r; end
      OP_CALL: begin ex_b = a_r; ex_a = pc_r; ex_pc_base = ex_pc_tgt; end
      OP_RETURN: begin ex_pc_base = a_r; ex_a = b_r; end
      OP_BRZ:  if (a_r == 32'd0) ex_pc_base = ex_pc_tgt;
      OP_BRLZ: if (a_r[31]) ex_pc_base = ex_pc_tgt;
      OP_BR:   ex_pc_base = ex_pc_tgt;
      OP_HALT: ex_halt = 1'b1;
      default: ;  // unknown opcode: no effect, still counted
    endcase
    ex_pc_next = ex_pc_base + 32'd1;
    ex_loop    = !ex_halt && (ex_pc_next == pc_r);
  end

  always_comb begin
    state_nxt  = state_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    pc_nxt     = pc_r;
    sp_nxt     = sp_r;
    cnt_nxt    = cnt_r;
    halted_nxt = halted_r;
    lp_nxt     = lp_r;
    rdata_nxt  = rdata_r;
    status_nxt = status_r;
    mem_en     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = pc_r[AW-1:0];
    mem_wdata  = in_data.object_word;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rdata_nxt  = 32'd0;
          status_nxt = ST_OK;
          unique case (in_data.func)
            FN_LOAD: begin
              state_nxt = S_DONE;
              if (ld_op <= OP_SET) begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = lp_r;
                mem_wdata = (ld_op >= OP_DATA) ? operand_of(in_data.object_word)
                                               : in_data.object_word;
                lp_nxt    = lp_r + 1'b1;
              end else begin
                status_nxt = ST_REJECT;
              end
            end
            FN_STEP: begin
              if (halted_r) begin
                status_nxt = ST_STOPPED;
                state_nxt  = S_DONE;
              end else begin
                mem_en    = 1'b1;
                mem_addr  = pc_r[AW-1:0];
                state_nxt = S_FETCH;
              end
            end
            FN_READ: begin
              mem_en    = 1'b1;
              mem_addr  = AW'(in_data.read_address);
              state_nxt = S_RDWAIT;
            end
            FN_RESTART: begin
              a_nxt      = 32'd0;
              b_nxt      = 32'd0;
              pc_nxt     = 32'd0;
              sp_nxt     = SP_INIT;
              cnt_nxt    = 32'd0;
              halted_nxt = 1'b0;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end
      S_FETCH: begin
        a_nxt     = ex_a;
        b_nxt     = ex_b;
        sp_nxt    = ex_sp;
        pc_nxt    = ex_pc_next;
        mem_en    = ex_rd || ex_wr;
        mem_we    = ex_wr;
        mem_addr  = ex_ea[AW-1:0];
        mem_wdata = ex_wdata;
        if (ex_halt) begin
          halted_nxt = 1'b1;
          status_nxt = ST_HALTED;
        end else if (ex_loop) begin
          halted_nxt = 1'b1;
          status_nxt = ST_LOOP;
        end else begin
          cnt_nxt = cnt_r + 32'd1;
        end
        state_nxt = ex_rd ? S_LDWAIT : S_DONE;
      end
      S_LDWAIT: begin
        a_nxt     = mem_rdata;
        state_nxt = S_DONE;
      end
      S_RDWAIT: begin
        rdata_nxt = mem_rdata;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      a_r      <= 32'd0;
      b_r      <= 32'd0;
      pc_r     <= 32'd0;
      sp_r     <= SP_INIT;
      cnt_r    <= 32'd0;
      halted_r <= 1'b0;
      lp_r     <= '0;
      rdata_r  <= 32'd0;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      a_r      <= a_nxt;
      b_r      <= b_nxt;
      pc_r     <= pc_nxt;
      sp_r     <= sp_nxt;
      cnt_r    <= cnt_nxt;
      halted_r <= halted_nxt;
      lp_r     <= lp_nxt;
      rdata_r  <= rdata_nxt;
      status_r <= status_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign res_valid = (state_r == S_DONE);

  always_comb begin
    res_data.program_counter = pc_r;
    res_data.stack_pointer   = sp_r;
    res_data.reg_a           = a_r;
    res_data.reg_b           = b_r;
    res_data.read_data       = rdata_r;
    res_data.status          = status_r;
    res_data.executed_count  = cnt_r;
  end

  // A stopped machine never reaches execute
  a_no_exec_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FETCH |-> !halted_r)
    else $error("execute entered while machine stopped");

  // Count only steps by one or clears on restart
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != $past(cnt_r) |-> cnt_r == $past(cnt_r) + 32'd1 || cnt_r == 32'd0)
    else $error("executed count moved by other than one");

  // Load pointer moves only after an accepted load
  a_lp_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    lp_r != $past(lp_r) |-> $past(in_acc) && $past(in_data.func) == FN_LOAD)
    else $error("load pointer moved without a load");

endmodule

// ----- src/simple_accumulator_stack_cpu_top.sv -----
// Top level of the two-register stack machine: core, word memory, result register.
// Depends on sasc_pkg, sasc_mem and sasc_core.
//
//   channel | ports                          | payload
//   --------+--------------------------------+------------------------------------
//   input   | in_valid, in_stall, in_data    | in_item_t: func, object_word, addr
//   result  | out_valid, out_stall, out_data | out_item_t: PC, SP, A, B, data, ...
//
// To result ready: load, restart and step while stopped go straight to S_DONE; step
// passes S_FETCH, read S_RDWAIT, ldl/ldnl S_FETCH then S_LDWAIT (one memory port:
// fetch, then data access). One item is in the core at a time; the next transfer is
// taken once the result moves into the output register, even if it is stalled.
// Reset: rst_n synchronous, active low; clears machine registers and load pointer.
// Memory contents are not reset and are undefined until written.
module simple_accumulator_stack_cpu_top
  import sasc_pkg::*;
#(
  // Word count of the memory; a power of two so address wrap is a bit mask
  parameter int MEM_DEPTH = 16384
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int AW = $clog2(MEM_DEPTH);

  logic          res_valid;
  logic          res_ready;
  out_item_t     res_data;
  logic          mem_en;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata;
  logic [31:0]   mem_rdata;

  logic          out_valid_r;
  out_item_t     out_data_r;

  sasc_core #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .mem_en    (mem_en),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  sasc_mem #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_mem (
    .clk       (clk),
    .mem_en    (mem_en),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  // Output register: loads when empty or when its current result transfers out
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- tb/simple_accumulator_stack_cpu_top_test.sv -----
`timescale 1ns / 100ps
// Self-checking test of simple_accumulator_stack_cpu_top: a stimulus table, then random
// load/step/read/restart traffic; each result checked against a shadow machine or a typed row.
// Depends on sasc_pkg and the RTL under src/.
module simple_accumulator_stack_cpu_top_test
  import sasc_pkg::*;
();

  localparam int DEPTH        = 16384;
  localparam int RAND_ITEMS   = 1300;
  localparam int DRAIN_AT     = 800;   // sender waits for all results here
  localparam int HOLD_AT      = 400;   // receiver's long hold-off starts here
  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 2000;  // cycles with no transfer before giving up
  localparam int TAIL_CYCLES  = 16;

  typedef enum logic [1:0] {MS_RUN, MS_HALT, MS_LOOP} mach_state_t;

  typedef struct {
    in_item_t   stim;
    bit         typed;    // expected result written out below
    logic [2:0] status;
  } dir_row_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  simple_accumulator_stack_cpu_top #(.MEM_DEPTH(DEPTH)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow machine: memory image, which words hold data, and the registers.
  // ---------------------------------------------------------------------------
  logic [31:0] shadow_mem [0:DEPTH-1];
  bit          written    [0:DEPTH-1];
  logic [13:0] written_list [$];
  logic [31:0] mach_a, mach_b, mach_pc, mach_sp, mach_count;
  logic [13:0] load_ptr;
  mach_state_t mach_state;

  out_item_t   machine_snapshots [$];   // machine state expected after each transfer

  int errors, in_count, results_seen, sent;
  int n_halt, n_loop, n_reject, n_stopped;
  bit hold_done;

  dir_row_t dir_rows [0:31];
  int       n_rows;

  function automatic void store_word(input logic [13:0] addr, input logic [31:0] data);
    shadow_mem[addr] = data;
    if (!written[addr]) begin
      written[addr] = 1'b1;
      written_list.push_back(addr);
    end
  endfunction

  function automatic void restart_machine();
    mach_a     = '0;
    mach_b     = '0;
    mach_pc    = '0;
    mach_sp    = DEPTH - 1;
    mach_count = '0;
    mach_state = MS_RUN;
  endfunction

  // One instruction at PC; returns the status code of the step.
  function automatic logic [2:0] exec_step();
    logic [31:0] w, opd, old_pc, ea;
    logic [7:0]  opc;
    if (mach_state != MS_RUN) return ST_STOPPED;
    old_pc = mach_pc;
    w      = shadow_mem[mach_pc[13:0]];
    opc    = w[7:0];
    opd    = $signed(w) >>> 8;
    case (opc)
      OP_LDC: begin
        mach_b = mach_a;
        mach_a = opd;
      end
      OP_ADC:  mach_a = mach_a + opd;
      OP_LDL: begin
        ea     = mach_sp + opd;
        mach_b = mach_a;
        mach_a = shadow_mem[ea[13:0]];
      end
      OP_STL: begin
        ea = mach_sp + opd;
        store_word(ea[13:0], mach_a);
        mach_a = mach_b;
      end
      OP_LDNL: begin
        ea     = mach_a + opd;
        mach_a = shadow_mem[ea[13:0]];
      end
      OP_STNL: begin
        ea = mach_a + opd;
        store_word(ea[13:0], mach_b);
      end
      OP_ADD:  mach_a = mach_a + mach_b;
      OP_SUB:  mach_a = mach_b - mach_a;
      OP_SHL:  mach_a = mach_b << mach_a[4:0];
      OP_SHR:  mach_a = $signed(mach_b) >>> mach_a[4:0];
      OP_ADJ:  mach_sp = mach_sp + opd;
      OP_A2SP: begin
        mach_sp = mach_a;
        mach_a  = mach_b;
      end
      OP_SP2A: begin
        mach_b = mach_a;
        mach_a = mach_sp;
      end
      OP_CALL: begin
        mach_b  = mach_a;
        mach_a  = mach_pc;
        mach_pc = mach_pc + opd;
      end
      OP_RETURN: begin
        mach_pc = mach_a;
        mach_a  = mach_b;
      end
      OP_BRZ:  if (mach_a == 0) mach_pc = mach_pc + opd;
      OP_BRLZ: if (mach_a[31]) mach_pc = mach_pc + opd;
      OP_BR:   mach_pc = mach_pc + opd;
      OP_HALT: begin
        mach_pc    = mach_pc + 1;
        mach_state = MS_HALT;
        return ST_HALTED;
      end
      default: ;  // undefined opcodes do nothing but still count
    endcase
    mach_pc = mach_pc + 1;
    if (mach_pc == old_pc) begin
      mach_state = MS_LOOP;
      return ST_LOOP;
    end
    mach_count = mach_count + 1;
    return ST_OK;
  endfunction

  // Applies one transfer to the shadow machine and returns the state it leaves.
  function automatic out_item_t advance_machine(input in_item_t it);
    out_item_t  r;
    logic [7:0] opc;
    r   = '0;
    opc = it.object_word[7:0];
    case (it.func)
      FN_LOAD: begin
        if (opc <= OP_SET) begin
          store_word(load_ptr, (opc >= OP_DATA) ? operand_of(it.object_word)
                                                : it.object_word);
          load_ptr = load_ptr + 14'd1;
        end else begin
          r.status = ST_REJECT;
        end
      end
      FN_STEP:  r.status = exec_step();
      FN_READ:  r.read_data = shadow_mem[it.read_address];
      default:  restart_machine();
    endcase
    r.program_counter = mach_pc;
    r.stack_pointer   = mach_sp;
    r.reg_a           = mach_a;
    r.reg_b           = mach_b;
    r.executed_count  = mach_count;
    case (r.status)
      ST_HALTED:  n_halt++;
      ST_LOOP:    n_loop++;
      ST_REJECT:  n_reject++;
      ST_STOPPED: n_stopped++;
      default: ;
    endcase
    return r;
  endfunction

  // True when the item would touch a word that nothing has written yet.
  function automatic bit touches_unwritten(input in_item_t it);
    logic [31:0] w, opd, ea;
    if (it.func == FN_READ) return !written[it.read_address];
    if (it.func != FN_STEP || mach_state != MS_RUN) return 1'b0;
    if (!written[mach_pc[13:0]]) return 1'b1;
    w   = shadow_mem[mach_pc[13:0]];
    opd = $signed(w) >>> 8;
    if (w[7:0] == OP_LDL) begin
      ea = mach_sp + opd;
      return !written[ea[13:0]];
    end
    if (w[7:0] == OP_LDNL) begin
      ea = mach_a + opd;
      return !written[ea[13:0]];
    end
    return 1'b0;
  endfunction

  // Machine state right after reset or restart, with the given status.
  function automatic out_item_t restart_result(input logic [2:0] status);
    out_item_t r;
    r               = '0;
    r.stack_pointer = DEPTH - 1;
    r.status        = status;
    return r;
  endfunction

  function automatic void add_row(input logic [1:0] f, input logic [31:0] w,
                                  input logic [13:0] addr, input bit typed,
                                  input logic [2:0] status);
    dir_rows[n_rows].stim   = '{func: f, object_word: w, read_address: addr};
    dir_rows[n_rows].typed  = typed;
    dir_rows[n_rows].status = status;
    n_rows++;
  endfunction

  // Object word: mostly real instructions with small offsets, some data
  // directives, some words the loader must reject.
  function automatic logic [31:0] rand_word();
    logic [7:0]  opc;
    logic [23:0] opd;
    int          sel;
    sel = $urandom_range(0, 99);
    if (sel < 85)      opc = 8'($urandom_range(OP_LDC, OP_HALT));
    else if (sel < 92) opc = sel[0] ? OP_DATA : OP_SET;
    else               opc = 8'($urandom_range(OP_SET + 1, 255));
    sel = $urandom_range(0, 9);
    if (sel < 6)      opd = 24'($urandom_range(0, 6) - 3);
    else if (sel < 8) opd = 24'($urandom_range(0, 40) - 20);
    else              opd = 24'($urandom);
    return {opd, opc};
  endfunction

  function automatic in_item_t rand_item(input logic [1:0] f);
    in_item_t it;
    it.func         = f;
    it.object_word  = (f == FN_LOAD) ? rand_word() : $urandom;
    it.read_address = 14'($urandom);
    if (f == FN_READ && written_list.size() > 0)
      it.read_address = written_list[$urandom_range(0, written_list.size() - 1)];
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of back-to-back transfers separated by random gaps.
  // Prediction runs at the edge that completes the transfer.
  // ---------------------------------------------------------------------------
  int burst_left;

  task automatic offer(input in_item_t it, input bit typed, input out_item_t typed_res);
    out_item_t r;
    int        gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = advance_machine(it);
    machine_snapshots.push_back(typed ? typed_res : r);
    in_count++;
    burst_left--;
  endtask

  // Random item, swapped for a load or a restart if it would read unwritten memory.
  task automatic offer_random(input logic [1:0] f);
    in_item_t it;
    it = rand_item(f);
    if (touches_unwritten(it))
      it = rand_item($urandom_range(0, 1) ? FN_LOAD : FN_RESTART);
    offer(it, 1'b0, '0);
    sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int i, n, pick;
    logic [1:0] f;
    bit noise, drained;

    load_ptr = '0;
    restart_machine();
    drained = 1'b0;

    // Directed table. Loads land at words 0..4; the steps then walk them
    // through ldc, stl at the top word, a data directive read back as ldc,
    // an undefined opcode and HALT, then one step while stopped.
    add_row(FN_RESTART, 32'h0,                  14'h0,    1'b1, ST_OK);
    add_row(FN_LOAD,    {24'h7fffff, OP_LDC},   14'h3fff, 1'b1, ST_OK);
    add_row(FN_LOAD,    {24'h000000, OP_STL},   14'h0,    1'b1, ST_OK);
    add_row(FN_LOAD,    {24'h800000, OP_DATA},  14'h0,    1'b1, ST_OK);
    add_row(FN_LOAD,    {24'h123456, 8'hff},    14'h0,    1'b1, ST_REJECT);
    add_row(FN_LOAD,    {24'hffffff, OP_SET},   14'h0,    1'b1, ST_OK);
    add_row(FN_LOAD,    {24'h000000, OP_HALT},  14'h0,    1'b1, ST_OK);
    add_row(FN_STEP,    32'hffffffff,           14'h3fff, 1'b0, ST_OK);
    add_row(FN_STEP,    32'h0,                  14'h0,    1'b0, ST_OK);
    add_row(FN_STEP,    32'h0,                  14'h0,    1'b0, ST_OK);
    add_row(FN_STEP,    32'h0,                  14'h0,    1'b0, ST_OK);
    add_row(FN_STEP,    32'h0,                  14'h0,    1'b0, ST_OK);
    add_row(FN_STEP,    32'h0,                  14'h0,    1'b0, ST_OK);
    add_row(FN_READ,    32'h0,                  14'h3fff, 1'b0, ST_OK);
    add_row(FN_READ,    32'hffffffff,           14'h0,    1'b0, ST_OK);
    add_row(FN_RESTART, 32'hffffffff,           14'h3fff, 1'b1, ST_OK);
    add_row(FN_LOAD,    32'hffffffff,           14'h0,    1'b1, ST_REJECT);
    add_row(FN_LOAD,    {24'h000001, OP_ADC},   14'h0,    1'b1, ST_OK);
    add_row(FN_STEP,    32'h0,                  14'h0,    1'b0, ST_OK);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < n_rows; i++)
      offer(dir_rows[i].stim, dir_rows[i].typed, restart_result(dir_rows[i].status));

    // Random episodes: program loads, restarts followed by runs, step runs,
    // reads of written words, and a little noise of any kind.
    while (sent < RAND_ITEMS) begin
      if (!drained && sent >= DRAIN_AT) begin
        in_valid <= 1'b0;
        while (machine_snapshots.size() != 0) @(posedge clk);
        drained = 1'b1;
      end
      pick  = $urandom_range(0, 99);
      noise = 1'b0;
      if (pick < 12) begin
        f = FN_LOAD;
        n = $urandom_range(1, 10);
      end else if (pick < 22) begin
        offer_random(FN_RESTART);
        f = FN_STEP;
        n = $urandom_range(5, 40);
      end else if (pick < 72) begin
        f = FN_STEP;
        n = $urandom_range(1, 30);
      end else if (pick < 84) begin
        f = FN_READ;
        n = $urandom_range(1, 4);
      end else begin
        noise = 1'b1;
        f = FN_LOAD;
        n = $urandom_range(1, 3);
      end
      repeat (n) offer_random(noise ? 2'($urandom_range(0, 3)) : f);
    end

    in_valid <= 1'b0;
    while (machine_snapshots.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run: %0d input transfers, %0d results checked, %0d words touched",
             in_count, results_seen, written_list.size());
    $display("Stops seen: %0d HALT, %0d self-branch, %0d stopped steps, %0d rejected loads",
             n_halt, n_loop, n_stopped, n_reject);
    if (errors == 0 && machine_snapshots.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: switches among four stall patterns (none, light, heavy, alternating); once, a long
  // hold-off lets the block fill and push back on the input.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int mode, left;
    left = 0;
    mode = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (!hold_done && in_count >= HOLD_AT) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(16, 96);
        end
        left--;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check, oldest expectation first
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (machine_snapshots.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %h", $time, out_data);
      end else begin
        want = machine_snapshots.pop_front();
        check_field("program_counter", want.program_counter, out_data.program_counter);
        check_field("stack_pointer",   want.stack_pointer,   out_data.stack_pointer);
        check_field("reg_a",           want.reg_a,           out_data.reg_a);
        check_field("reg_b",           want.reg_b,           out_data.reg_b);
        check_field("read_data",       want.read_data,       out_data.read_data);
        check_field("status",          32'(want.status),     32'(out_data.status));
        check_field("executed_count",  want.executed_count,  out_data.executed_count);
      end
    end
  end

  // Watchdog: too long without any transfer on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst_n);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: timeout, %0d cycles without a transfer, %0d results outstanding",
             $time, quiet, machine_snapshots.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
